// ===== src/pwbl_pkg.sv =====
// Shared constants for the pulse-width board link receiver.
`timescale 1ns / 1ps
`default_nettype none

package pwbl_pkg;

  // Fixed field widths of the item payloads.
  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 5;
  localparam int COORD_W  = 3;
  localparam int NIBBLE_W = 4;
  localparam int PIECE_W  = 3;
  localparam int BITPOS_W = 3;

  // Last bit position of a byte; bits arrive MSB first.
  localparam logic [BITPOS_W-1:0] BIT_LAST = 3'd7;

endpackage

`default_nettype wire

// ===== src/pwbl_ifs.sv =====
// Valid/ready channel interfaces for line samples and receiver results.
`timescale 1ns / 1ps
`default_nettype none

interface pwbl_sample_if;
  logic                           valid;
  logic                           ready;
  logic                           link_reset_n;
  logic                           line_level;
  logic [pwbl_pkg::COORD_W-1:0]   query_col;
  logic [pwbl_pkg::COORD_W-1:0]   query_row;

  modport source (output valid, link_reset_n, line_level, query_col, query_row,
                  input ready);
  modport sink (input valid, link_reset_n, line_level, query_col, query_row,
                output ready);
endinterface

interface pwbl_result_if;
  logic                           valid;
  logic                           ready;
  logic                           byte_done;
  logic [pwbl_pkg::BYTE_W-1:0]    byte_value;
  logic [pwbl_pkg::SLOT_W-1:0]    byte_slot;
  logic [pwbl_pkg::PIECE_W-1:0]   piece_code;
  logic                           piece_black;

  modport source (output valid, byte_done, byte_value, byte_slot, piece_code,
                  piece_black, input ready);
  modport sink (input valid, byte_done, byte_value, byte_slot, piece_code,
                piece_black, output ready);
endinterface

`default_nettype wire

// ===== src/pwbl_board_store.sv =====
// Board byte store with per-entry valid bits and a registered query read.
`timescale 1ns / 1ps
`default_nettype none

module pwbl_board_store #(
  parameter int DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [pwbl_pkg::BYTE_W-1:0]   wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  input  wire logic                          rd_zero,
  output logic      [pwbl_pkg::BYTE_W-1:0]   rd_data
);
  import pwbl_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;

  logic [BYTE_W-1:0] mem_q;
  logic              written_q;
  logic              hit_q;
  logic [BYTE_W-1:0] wdata_q;
  logic              zero_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Entries never written read as zero, matching the cleared board at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // The query sees this item's write, so a same-address write is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      written_q <= written[rd_addr];
      hit_q     <= wr_en && (wr_addr == rd_addr);
      wdata_q   <= wr_data;
      zero_q    <= rd_zero;
    end
  end

  always_comb begin
    if (zero_q) begin
      rd_data = '0;
    end else if (hit_q) begin
      rd_data = wdata_q;
    end else if (written_q) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/pulse_width_board_link_receiver.sv =====
// Top level of the pulse-width board link receiver.
//
// The sample channel carries one tick of the serial line per item: the line
// level, an active-low link reset and a board square to query. The result
// channel returns exactly one item per sample: a flag and the byte and slot
// when that tick completed a byte, plus the piece code and color bit stored
// for the queried square (read after this tick's own store write).
//
// The result is registered: a sample accepted at one edge has its result valid
// after it. One item per cycle is taken unless stalled; the edge detector, the
// duration compare and the store write all finish in the accepting cycle.
// The result register parts the channels: a new sample is taken whenever the
// result register is empty or its item is taken in the same cycle. When the
// result receiver stalls, the result holds and the sample side is stalled.
//
// Reset (rst, synchronous) clears the receiver state and the board valid
// bits, so every square reads as empty; the block accepts items in the first
// cycle after reset. Durations are counted in accepted items and saturate at
// the timer's full scale.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_board_link_receiver #(
  parameter int STORE_BYTES = 32,
  parameter int ROW_BYTES   = 4,
  parameter int TIMER_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  pwbl_sample_if.sink   sample,
  pwbl_result_if.source result
);
  import pwbl_pkg::*;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  // Wide enough for row * ROW_BYTES + col / 2 at the largest coordinates.
  localparam int QIDX_W = $clog2(8 * ROW_BYTES + 4);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [ADDR_W-1:0]     SLOT_LAST = ADDR_W'(STORE_BYTES - 1);

  // Receiver state.
  logic                  last_level;
  logic                  armed;
  logic [BITPOS_W-1:0]   bit_position;
  logic [BYTE_W-1:0]     assembly_byte;
  logic [ADDR_W-1:0]     write_slot;
  logic [TIMER_BITS-1:0] ticks_since_edge;
  logic [TIMER_BITS-1:0] low_duration;

  logic                  last_level_next;
  logic                  armed_next;
  logic [BITPOS_W-1:0]   bit_position_next;
  logic [BYTE_W-1:0]     assembly_byte_next;
  logic [ADDR_W-1:0]     write_slot_next;
  logic [TIMER_BITS-1:0] ticks_since_edge_next;
  logic [TIMER_BITS-1:0] low_duration_next;

  // Result register.
  logic                  out_valid;
  logic                  out_done;
  logic [BYTE_W-1:0]     out_value;
  logic [SLOT_W-1:0]     out_slot;
  logic                  out_odd;

  logic                  accept;
  logic                  store_wr;
  logic [QIDX_W-1:0]     query_idx;
  logic                  query_zero;
  logic [BYTE_W-1:0]     square_byte;
  logic [NIBBLE_W-1:0]   square_nibble;

  // Work values after the link reset has been applied.
  logic                  prev_level;
  logic                  cur_armed;
  logic [BITPOS_W-1:0]   cur_bitpos;
  logic [ADDR_W-1:0]     cur_slot;
  logic [TIMER_BITS-1:0] cur_ticks;
  logic                  fall;
  logic                  rise;

  assign sample.ready = !out_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  always_comb begin
    // A link reset latches the line level first, so no edge shows this tick.
    prev_level = sample.link_reset_n ? last_level : sample.line_level;
    cur_armed  = sample.link_reset_n && armed;
    cur_bitpos = sample.link_reset_n ? bit_position : '0;
    cur_slot   = sample.link_reset_n ? write_slot : '0;
    cur_ticks  = sample.link_reset_n ? ticks_since_edge : '0;

    fall = !sample.line_level && prev_level;
    rise = sample.line_level && !prev_level;

    armed_next         = cur_armed;
    bit_position_next  = cur_bitpos;
    assembly_byte_next = assembly_byte;
    write_slot_next    = cur_slot;
    low_duration_next  = low_duration;
    store_wr           = 1'b0;

    if (fall) begin
      if (cur_armed) begin
        // Long low followed by a shorter high encodes a one.
        assembly_byte_next[BIT_LAST - cur_bitpos] = (low_duration > cur_ticks);
        bit_position_next = cur_bitpos + 1'b1;
        if (cur_bitpos == BIT_LAST) begin
          store_wr = 1'b1;
          if (cur_slot == SLOT_LAST) begin
            write_slot_next = '0;
            armed_next      = 1'b0;
          end else begin
            write_slot_next = cur_slot + 1'b1;
          end
        end
      end
      cur_ticks = '0;
    end else if (rise) begin
      low_duration_next = cur_ticks;
      armed_next        = 1'b1;
      cur_ticks         = '0;
    end

    last_level_next       = sample.line_level;
    ticks_since_edge_next = (cur_ticks == TIMER_MAX) ? cur_ticks : cur_ticks + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level       <= 1'b0;
      armed            <= 1'b0;
      bit_position     <= '0;
      assembly_byte    <= '0;
      write_slot       <= '0;
      ticks_since_edge <= '0;
      low_duration     <= '0;
    end else if (accept) begin
      last_level       <= last_level_next;
      armed            <= armed_next;
      bit_position     <= bit_position_next;
      assembly_byte    <= assembly_byte_next;
      write_slot       <= write_slot_next;
      ticks_since_edge <= ticks_since_edge_next;
      low_duration     <= low_duration_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Byte and slot read as zero on ticks that complete no byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_done  <= store_wr;
      out_value <= store_wr ? assembly_byte_next : '0;
      out_slot  <= store_wr ? SLOT_W'(cur_slot) : '0;
      out_odd   <= sample.query_col[0];
    end
  end

  // Two squares share a byte: even column in the high nibble, odd in the low.
  assign query_idx  = QIDX_W'(sample.query_row) * QIDX_W'(ROW_BYTES)
                    + QIDX_W'(sample.query_col[COORD_W-1:1]);
  assign query_zero = (32'(query_idx) >= 32'(STORE_BYTES));

  pwbl_board_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && store_wr),
    .wr_addr (cur_slot),
    .wr_data (assembly_byte_next),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(query_idx)),
    .rd_zero (query_zero),
    .rd_data (square_byte)
  );

  assign square_nibble = out_odd ? square_byte[NIBBLE_W-1:0]
                                 : square_byte[BYTE_W-1:NIBBLE_W];

  assign result.valid       = out_valid;
  assign result.byte_done   = out_done;
  assign result.byte_value  = out_value;
  assign result.byte_slot   = out_slot;
  assign result.piece_code  = square_nibble[PIECE_W-1:0];
  assign result.piece_black = square_nibble[NIBBLE_W-1];

  // A link reset leaves the receiver at the start of a fresh frame.
  a_link_reset_clears: assert property (@(posedge clk) disable iff (rst)
    accept && !sample.link_reset_n |=>
      bit_position == '0 && write_slot == '0 && !armed &&
      last_level == $past(sample.line_level))
    else $error("link reset did not restart the receiver");

  // The eighth bit of an armed frame always produces a stored byte.
  a_byte_completes: assert property (@(posedge clk) disable iff (rst)
    accept && fall && cur_armed && cur_bitpos == BIT_LAST |=>
      out_done && out_slot == SLOT_W'($past(cur_slot)))
    else $error("completed byte not reported");

  // Filling the last slot wraps the index and disarms the receiver.
  a_wrap_disarms: assert property (@(posedge clk) disable iff (rst)
    accept && store_wr && cur_slot == SLOT_LAST |=> !armed && write_slot == '0)
    else $error("store wrap did not disarm");

endmodule

`default_nettype wire
